FILE: sv/assert_macros.svh
// Assertion macros for the checker file.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define ASSERT_ON(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Same, on the block clock clk_i and reset rst_ni.
`define ASSERT_STD(lbl, prop) `ASSERT_ON(lbl, clk_i, rst_ni, prop)

`endif

FILE: sv/bzs_pkg.sv
// Shared constants for the Bezier split pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bzs_pkg;

  // Curve degree codes
  localparam logic [1:0] DEG_LINE  = 2'd1;
  localparam logic [1:0] DEG_QUAD  = 2'd2;
  localparam logic [1:0] DEG_CUBIC = 2'd3;

  // Register stages inside one interpolation cell
  localparam int unsigned CELL_STAGES = 3;

  // Interpolation levels of a cubic
  localparam int unsigned NUM_LEVELS = 3;

endpackage

`default_nettype wire

FILE: sv/bezier_split_de_casteljau.sv
// Pipeline: input beat to result beat through three levels of
//   interpolation cells, each cell three register stages: subtract, multiply, round.
// Throughput: one segment per cycle; the whole chain holds while a result
//   beat waits, set by the single multiplier stage in each cell.
// Reset: asynchronous, active low; clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module bezier_split_de_casteljau #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             degree_i,
  input  wire logic [COORD_WIDTH-1:0] start_x_i,
  input  wire logic [COORD_WIDTH-1:0] start_y_i,
  input  wire logic [COORD_WIDTH-1:0] ctrl_a_x_i,
  input  wire logic [COORD_WIDTH-1:0] ctrl_a_y_i,
  input  wire logic [COORD_WIDTH-1:0] ctrl_b_x_i,
  input  wire logic [COORD_WIDTH-1:0] ctrl_b_y_i,
  input  wire logic [COORD_WIDTH-1:0] end_x_i,
  input  wire logic [COORD_WIDTH-1:0] end_y_i,
  input  wire logic [T_FRAC_BITS:0]   t_param_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [COORD_WIDTH-1:0] split_x_o,
  output logic      [COORD_WIDTH-1:0] split_y_o,
  output logic      [COORD_WIDTH-1:0] left_first_x_o,
  output logic      [COORD_WIDTH-1:0] left_first_y_o,
  output logic      [COORD_WIDTH-1:0] left_second_x_o,
  output logic      [COORD_WIDTH-1:0] left_second_y_o,
  output logic      [COORD_WIDTH-1:0] right_first_x_o,
  output logic      [COORD_WIDTH-1:0] right_first_y_o,
  output logic      [COORD_WIDTH-1:0] right_second_x_o,
  output logic      [COORD_WIDTH-1:0] right_second_y_o
);

  import bzs_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned TF    = T_FRAC_BITS;
  localparam int unsigned DEPTH = NUM_LEVELS * CELL_STAGES;
  localparam logic [TF:0] T_ONE = {1'b1, {TF{1'b0}}};

  // pipeline control: the chain moves unless a result beat is stuck
  logic             adv;
  logic [DEPTH-1:0] vld_q, vld_d;

  assign adv        = !vld_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = adv;
  assign vld_d      = {vld_q[DEPTH-2:0], in_valid_i};
  assign out_valid_o = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // t above one saturates to one
  logic [TF:0] t_sat;
  assign t_sat = (t_param_i > T_ONE) ? T_ONE : t_param_i;

  // degree travels alongside the data
  logic [1:0] deg_out;
  bzs_delay #(.WIDTH(2), .DEPTH(DEPTH)) u_deg_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (degree_i),
    .q_o   (deg_out)
  );

  logic is_cubic, is_quad;
  assign is_cubic = (degree_i == DEG_CUBIC);
  assign is_quad  = (degree_i == DEG_QUAD);

  // per-axis views of the ports
  logic [CW-1:0] p_start [2];
  logic [CW-1:0] p_ca    [2];
  logic [CW-1:0] p_cb    [2];
  logic [CW-1:0] p_end   [2];
  logic [CW-1:0] o_split [2];
  logic [CW-1:0] o_lf    [2];
  logic [CW-1:0] o_ls    [2];
  logic [CW-1:0] o_rf    [2];
  logic [CW-1:0] o_rs    [2];

  assign p_start[0] = start_x_i;
  assign p_start[1] = start_y_i;
  assign p_ca[0]    = ctrl_a_x_i;
  assign p_ca[1]    = ctrl_a_y_i;
  assign p_cb[0]    = ctrl_b_x_i;
  assign p_cb[1]    = ctrl_b_y_i;
  assign p_end[0]   = end_x_i;
  assign p_end[1]   = end_y_i;

  assign split_x_o        = o_split[0];
  assign split_y_o        = o_split[1];
  assign left_first_x_o   = o_lf[0];
  assign left_first_y_o   = o_lf[1];
  assign left_second_x_o  = o_ls[0];
  assign left_second_y_o  = o_ls[1];
  assign right_first_x_o  = o_rf[0];
  assign right_first_y_o  = o_rf[1];
  assign right_second_x_o = o_rs[0];
  assign right_second_y_o = o_rs[1];

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic [CW-1:0] a1_0, b1_0, a1_1, b1_1, a1_2, b1_2;
    logic [CW-1:0] r1_0, r1_1, r1_2, r2_0, r2_1, r3;
    logic [TF:0]   t1, t2;
    logic [3*CW-1:0] l1_dly;
    logic [2*CW-1:0] l2_dly;

    // level 1 operand pairs by degree; a line uses the first cell only
    assign a1_0 = p_start[ax];
    assign b1_0 = (is_cubic || is_quad) ? p_ca[ax] : p_end[ax];
    assign a1_1 = p_ca[ax];
    assign b1_1 = is_cubic ? p_cb[ax] : p_end[ax];
    assign a1_2 = is_cubic ? p_cb[ax] : p_end[ax];
    assign b1_2 = p_end[ax];

    // level 1
    bzs_lerp_cell #(.CW(CW), .TF(TF)) u_c10 (
      .clk_i(clk_i), .en_i(adv), .a_i(a1_0), .b_i(b1_0), .t_i(t_sat),
      .r_o(r1_0), .t_o(t1)
    );
    bzs_lerp_cell #(.CW(CW), .TF(TF)) u_c11 (
      .clk_i(clk_i), .en_i(adv), .a_i(a1_1), .b_i(b1_1), .t_i(t_sat),
      .r_o(r1_1), .t_o()
    );
    bzs_lerp_cell #(.CW(CW), .TF(TF)) u_c12 (
      .clk_i(clk_i), .en_i(adv), .a_i(a1_2), .b_i(b1_2), .t_i(t_sat),
      .r_o(r1_2), .t_o()
    );

    // level 2
    bzs_lerp_cell #(.CW(CW), .TF(TF)) u_c20 (
      .clk_i(clk_i), .en_i(adv), .a_i(r1_0), .b_i(r1_1), .t_i(t1),
      .r_o(r2_0), .t_o(t2)
    );
    bzs_lerp_cell #(.CW(CW), .TF(TF)) u_c21 (
      .clk_i(clk_i), .en_i(adv), .a_i(r1_1), .b_i(r1_2), .t_i(t1),
      .r_o(r2_1), .t_o()
    );

    // level 3
    bzs_lerp_cell #(.CW(CW), .TF(TF)) u_c30 (
      .clk_i(clk_i), .en_i(adv), .a_i(r2_0), .b_i(r2_1), .t_i(t2),
      .r_o(r3), .t_o()
    );

    // earlier levels wait for level 3
    bzs_delay #(.WIDTH(3*CW), .DEPTH(2*CELL_STAGES)) u_l1_dly (
      .clk_i(clk_i), .en_i(adv), .d_i({r1_2, r1_1, r1_0}), .q_o(l1_dly)
    );
    bzs_delay #(.WIDTH(2*CW), .DEPTH(CELL_STAGES)) u_l2_dly (
      .clk_i(clk_i), .en_i(adv), .d_i({r2_1, r2_0}), .q_o(l2_dly)
    );

    // pick the result fields by degree; unused fields are zero
    always_comb begin
      o_split[ax] = l1_dly[CW-1:0];
      o_lf[ax]    = '0;
      o_ls[ax]    = '0;
      o_rf[ax]    = '0;
      o_rs[ax]    = '0;
      case (deg_out)
        DEG_CUBIC: begin
          o_split[ax] = r3;
          o_lf[ax]    = l1_dly[CW-1:0];
          o_ls[ax]    = l2_dly[CW-1:0];
          o_rf[ax]    = l2_dly[2*CW-1:CW];
          o_rs[ax]    = l1_dly[3*CW-1:2*CW];
        end
        DEG_QUAD: begin
          o_split[ax] = l2_dly[CW-1:0];
          o_lf[ax]    = l1_dly[CW-1:0];
          o_rf[ax]    = l1_dly[2*CW-1:CW];
        end
        default: begin
          o_split[ax] = l1_dly[CW-1:0];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/bzs_lerp_cell.sv
// One interpolation cell: r = a + round((b - a) * t), three register stages.
// Standalone; instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none

module bzs_lerp_cell #(
  parameter int unsigned CW = 32,
  parameter int unsigned TF = 16
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [CW-1:0] a_i,
  input  wire logic [CW-1:0] b_i,
  input  wire logic [TF:0]   t_i,
  output logic      [CW-1:0] r_o,
  output logic      [TF:0]   t_o
);

  localparam int unsigned PW = CW + TF + 2;
  localparam logic [PW-1:0] HALF = PW'(1) << (TF - 1);

  // stage 1: difference and magnitude
  logic [CW:0] diff;
  logic [CW:0] mag;
  logic        neg;

  logic [CW-1:0] a1_q, a2_q;
  logic [CW:0]   mag1_q;
  logic          neg1_q, neg2_q;
  logic [TF:0]   t1_q, t2_q, t3_q;
  logic [PW-1:0] prod2_q;
  logic [CW-1:0] r3_q;

  assign diff = {b_i[CW-1], b_i} - {a_i[CW-1], a_i};
  assign neg  = diff[CW];
  assign mag  = neg ? (~diff + (CW+1)'(1)) : diff;

  // stage 3: round, then step from a toward b
  logic [PW-1:0] rnd;
  logic [CW:0]   step;
  logic [CW:0]   a_ext;
  logic [CW:0]   res;

  assign rnd   = prod2_q + HALF;
  assign step  = rnd[TF+CW:TF];
  assign a_ext = {a2_q[CW-1], a2_q};
  assign res   = neg2_q ? (a_ext - step) : (a_ext + step);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= a_i;
      mag1_q  <= mag;
      neg1_q  <= neg;
      t1_q    <= t_i;
      // stage 2: exact product
      a2_q    <= a1_q;
      neg2_q  <= neg1_q;
      t2_q    <= t1_q;
      prod2_q <= PW'(mag1_q) * PW'(t1_q);
      // stage 3 result
      r3_q    <= res[CW-1:0];
      t3_q    <= t2_q;
    end
  end

  assign r_o = r3_q;
  assign t_o = t3_q;

endmodule

`default_nettype wire

FILE: sv/bzs_delay.sv
// Enabled shift line that carries side data along the cell chain.
// Standalone; instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none

module bzs_delay #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 3
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_q [DEPTH];

  // taps shift together with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

`default_nettype wire

FILE: sv/bzs_checker.sv
// Port-level checks for the Bezier split block, bound to the top level.
// Depends on assert_macros.svh and bezier_split_de_casteljau.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bzs_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [COORD_WIDTH-1:0] split_x_o,
  input wire logic [COORD_WIDTH-1:0] split_y_o
);

  // result beat holds until taken
  `ASSERT_STD(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)

  // stalled result payload does not change
  `ASSERT_STD(a_out_stable,
    out_valid_o && !out_ready_i |=> $stable(split_x_o) && $stable(split_y_o))

  // a taken result always frees the input side
  `ASSERT_STD(a_ready_follows, out_ready_i |-> in_ready_o)

  // input backpressure only comes from a stalled result beat
  `ASSERT_STD(a_stall_cause, in_valid_i && !in_ready_o |-> out_valid_o && !out_ready_i)

endmodule

bind bezier_split_de_casteljau bzs_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_bzs_checker (.*);

`default_nettype wire
